// ===== hdl/twg_pkg.sv =====
package twg_pkg;

	localparam int PHASE_BITS_DEF      = 32;
	localparam int SINE_TABLE_BITS_DEF = 10;
	localparam int SAMPLE_BITS         = 16;
	localparam int PHASE_STEP_BITS     = 31;
	localparam int PERIOD_BITS         = 16;
	localparam int CFG_DATA_BITS       = 31;
	localparam int CFG_INDEX_BITS      = 2;

	localparam logic [PHASE_STEP_BITS-1:0] PHASE_STEP_RST      = 31'd214748;
	localparam logic [PERIOD_BITS-1:0]     SEQUENCE_PERIOD_RST = 16'd1000;
	localparam logic [PERIOD_BITS-1:0]     LED_PERIOD_RST      = 16'd5000;

	localparam logic [7:0] WAVE_SQUARE   = 8'd1;
	localparam logic [7:0] WAVE_TRIANGLE = 8'd2;

	// pi/2 in Q2.30.
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_PHASE_STEP      = 2'd0,
		CFG_SEQUENCE_PERIOD = 2'd1,
		CFG_LED_PERIOD      = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic [31:0] lock_before;
		logic [31:0] lock_after;
		logic [7:0]  mailbox_wave_type;
		logic [7:0]  mailbox_sequence;
	} tick_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] wave_sample;
		logic [31:0]                   sequence_out;
		logic [31:0]                   out_lock_count;
		logic [7:0]                    received_sequence;
		logic                          led_level;
	} result_t;

	typedef struct packed {
		logic [PHASE_STEP_BITS-1:0] phase_step;
		logic [PERIOD_BITS-1:0]     sequence_period;
		logic [PERIOD_BITS-1:0]     led_period;
	} cfg_t;

	typedef struct packed {
		logic [31:0] sequence_out;
		logic [31:0] out_lock_count;
		logic [7:0]  received_sequence;
		logic        led_level;
	} status_t;

	// Saturate a sample that carries one extra bit of headroom.
	function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
		input logic signed [SAMPLE_BITS:0] v
	);
		logic signed [SAMPLE_BITS:0] hi;
		logic signed [SAMPLE_BITS:0] lo;
		hi = (SAMPLE_BITS+1)'(2**(SAMPLE_BITS-1) - 1);
		lo = -hi - (SAMPLE_BITS+1)'(1);
		if (v > hi) begin
			return hi[SAMPLE_BITS-1:0];
		end else if (v < lo) begin
			return lo[SAMPLE_BITS-1:0];
		end
		return v[SAMPLE_BITS-1:0];
	endfunction

	// Quarter-wave sine magnitude for table entry q, evaluated at elaboration.
	// The angle is formed in Q2.30, the series runs to the 11th power, and the
	// result is rounded half up to the sample precision.
	function automatic logic [SAMPLE_BITS-1:0] sine_mag(input int q, input int table_bits);
		logic [63:0] frac;
		logic [63:0] theta;
		logic [63:0] t2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] mag;
		frac  = 64'(q) << (32 - table_bits);
		theta = (frac * HALF_PI_Q30) >> 30;
		t2    = (theta * theta) >> 30;
		term  = theta;
		sum   = theta;
		term  = ((term * t2) >> 30) / 6;
		sum   = sum - term;
		term  = ((term * t2) >> 30) / 20;
		sum   = sum + term;
		term  = ((term * t2) >> 30) / 42;
		sum   = sum - term;
		term  = ((term * t2) >> 30) / 72;
		sum   = sum + term;
		term  = ((term * t2) >> 30) / 110;
		sum   = sum - term;
		mag   = (sum + (64'd1 << (30 - SAMPLE_BITS))) >> (31 - SAMPLE_BITS);
		return mag[SAMPLE_BITS-1:0];
	endfunction

endpackage

// ===== hdl/twg_wave.sv =====
module twg_wave #(
	parameter int PHASE_BITS      = twg_pkg::PHASE_BITS_DEF,
	parameter int SINE_TABLE_BITS = twg_pkg::SINE_TABLE_BITS_DEF
) (
	input  logic [7:0]                             wave_type,
	input  logic [PHASE_BITS-1:0]                  phase,
	output logic signed [twg_pkg::SAMPLE_BITS-1:0] sample
);

	localparam int S     = twg_pkg::SAMPLE_BITS;
	localparam int QBITS = SINE_TABLE_BITS - 2;
	localparam int QSIZE = 1 << QBITS;
	localparam int W     = PHASE_BITS + S;
	localparam int TRI_SHR = (PHASE_BITS >= S + 1) ? PHASE_BITS - S - 1 : 0;
	localparam int TRI_SHL = (PHASE_BITS >= S + 1) ? 0 : S + 1 - PHASE_BITS;

	localparam logic signed [S-1:0] SQ_MAX = S'(2**(S-1) - 1);
	localparam logic signed [S-1:0] SQ_MIN = {1'b1, {(S-1){1'b0}}};
	localparam logic signed [S:0]   MID    = (S+1)'(2**(S-1));

	logic [S-1:0] sine_mag_w [QSIZE+1];

	// One quarter of the sine, both ends included; the other quarters mirror it.
	for (genvar g = 0; g <= QSIZE; g++) begin : g_sine
		localparam logic [S-1:0] MAG = twg_pkg::sine_mag(g, SINE_TABLE_BITS);
		assign sine_mag_w[g] = MAG;
	end

	logic [SINE_TABLE_BITS-1:0] idx;
	logic [1:0]                 quad;
	logic [QBITS:0]             q_sel;
	logic signed [S:0]          sine_pos;
	logic signed [S:0]          sine_val;
	logic [W-1:0]               tri_full;
	logic [S-1:0]               tri_x;
	logic signed [S:0]          tri_val;

	always_comb begin
		idx      = phase[PHASE_BITS-1 -: SINE_TABLE_BITS];
		quad     = idx[SINE_TABLE_BITS-1 -: 2];
		q_sel    = quad[0] ? ((QBITS+1)'(QSIZE) - {1'b0, idx[QBITS-1:0]})
		                   : {1'b0, idx[QBITS-1:0]};
		sine_pos = $signed({1'b0, sine_mag_w[q_sel]});
		sine_val = quad[1] ? -sine_pos : sine_pos;

		tri_full = (W'(phase[PHASE_BITS-2:0]) >> TRI_SHR) << TRI_SHL;
		tri_x    = tri_full[S-1:0];
		if (!phase[PHASE_BITS-1]) begin
			tri_val = $signed({1'b0, tri_x}) - MID;
		end else begin
			tri_val = MID - $signed({1'b0, tri_x});
		end

		case (wave_type)
			twg_pkg::WAVE_SQUARE:   sample = phase[PHASE_BITS-1] ? SQ_MIN : SQ_MAX;
			twg_pkg::WAVE_TRIANGLE: sample = twg_pkg::sat_sample(tri_val);
			default:                sample = twg_pkg::sat_sample(sine_val);
		endcase
	end

endmodule

// ===== hdl/twg_state.sv =====
module twg_state #(
	parameter int PHASE_BITS = twg_pkg::PHASE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  twg_pkg::cfg_t         cfg,
	input  logic                  step,
	input  twg_pkg::tick_t        tick,
	output logic [PHASE_BITS-1:0] phase,
	output logic [7:0]            wave_type,
	output twg_pkg::status_t      status
);

	logic [PHASE_BITS-1:0]           phase_q;
	logic [7:0]                      wave_type_q;
	logic [7:0]                      held_sequence_q;
	logic [twg_pkg::PERIOD_BITS-1:0] prescale_count_q;
	logic [31:0]                     sequence_q;
	logic [twg_pkg::PERIOD_BITS-1:0] led_count_q;
	logic                            led_state_q;
	logic [31:0]                     lock_count_q;

	logic [twg_pkg::PERIOD_BITS-1:0] pre_inc;
	logic [twg_pkg::PERIOD_BITS-1:0] led_inc;
	logic                            pre_hit;
	logic                            led_hit;
	logic                            mbox_ok;

	always_comb begin
		pre_inc = prescale_count_q + 16'd1;
		led_inc = led_count_q + 16'd1;
		pre_hit = pre_inc >= cfg.sequence_period;
		led_hit = led_inc >= cfg.led_period;
		// The mailbox is consistent only when the writer was not mid-update.
		mbox_ok = !tick.lock_before[0] && (tick.lock_before == tick.lock_after);

		status.sequence_out      = sequence_q;
		status.out_lock_count    = lock_count_q + 32'd2;
		status.received_sequence = mbox_ok ? tick.mailbox_sequence : held_sequence_q;
		status.led_level         = led_state_q ^ led_hit;
	end

	assign phase     = phase_q;
	assign wave_type = wave_type_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= '0;
			wave_type_q      <= '0;
			held_sequence_q  <= '0;
			prescale_count_q <= '0;
			sequence_q       <= '0;
			led_count_q      <= '0;
			led_state_q      <= 1'b0;
			lock_count_q     <= '0;
		end else if (step) begin
			phase_q      <= phase_q + PHASE_BITS'(cfg.phase_step);
			lock_count_q <= status.out_lock_count;
			if (mbox_ok) begin
				wave_type_q     <= tick.mailbox_wave_type;
				held_sequence_q <= tick.mailbox_sequence;
			end
			if (pre_hit) begin
				prescale_count_q <= '0;
				sequence_q       <= sequence_q + 32'd1;
			end else begin
				prescale_count_q <= pre_inc;
			end
			led_count_q <= led_hit ? '0 : led_inc;
			led_state_q <= status.led_level;
		end
	end

endmodule

// ===== hdl/tick_waveform_generator_unit.sv =====
// Channel   Direction  Handshake                 Payload
// tick      in         tick_valid / tick_stall   twg_pkg::tick_t
// result    out        result_valid / result_stall twg_pkg::result_t
// config    in         cfg_write (no handshake)  cfg_index, cfg_data
//
// One tick is taken every cycle while tick_stall is low. It is held in the input
// register, and its result in the output register, which drives result_valid.
// The sample, phase and counters are all worked out combinationally between them.
// Reset loads the register defaults and clears phase, wave type and all counters.
// A stalled result holds; the input register still fills behind it, and only then
// does tick_stall rise.
module tick_waveform_generator_unit #(
	parameter int PHASE_BITS      = twg_pkg::PHASE_BITS_DEF,
	parameter int SINE_TABLE_BITS = twg_pkg::SINE_TABLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write,
	input  logic [twg_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [twg_pkg::CFG_DATA_BITS-1:0]     cfg_data,
	input  logic                                  tick_valid,
	output logic                                  tick_stall,
	input  twg_pkg::tick_t                        tick,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output twg_pkg::result_t                      result
);

	twg_pkg::cfg_t    cfg_q;
	twg_pkg::tick_t   tick_s1;
	logic             valid_s1;
	twg_pkg::result_t result_s2;
	logic             valid_s2;

	logic                                  advance;
	logic                                  fire;
	logic [PHASE_BITS-1:0]                 phase;
	logic [7:0]                            wave_type;
	logic signed [twg_pkg::SAMPLE_BITS-1:0] sample;
	twg_pkg::status_t                      status;

	assign advance    = !valid_s2 || !result_stall;
	assign fire       = valid_s1 && advance;
	assign tick_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_step      <= twg_pkg::PHASE_STEP_RST;
			cfg_q.sequence_period <= twg_pkg::SEQUENCE_PERIOD_RST;
			cfg_q.led_period      <= twg_pkg::LED_PERIOD_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				twg_pkg::CFG_PHASE_STEP:      cfg_q.phase_step      <= cfg_data;
				twg_pkg::CFG_SEQUENCE_PERIOD: cfg_q.sequence_period <= cfg_data[15:0];
				twg_pkg::CFG_LED_PERIOD:      cfg_q.led_period      <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!tick_stall) begin
				valid_s1 <= tick_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!tick_stall && tick_valid) begin
			tick_s1 <= tick;
		end
		if (fire) begin
			result_s2.wave_sample       <= sample;
			result_s2.sequence_out      <= status.sequence_out;
			result_s2.out_lock_count    <= status.out_lock_count;
			result_s2.received_sequence <= status.received_sequence;
			result_s2.led_level         <= status.led_level;
		end
	end

	twg_state #(
		.PHASE_BITS(PHASE_BITS)
	) u_state (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.step     (fire),
		.tick     (tick_s1),
		.phase    (phase),
		.wave_type(wave_type),
		.status   (status)
	);

	twg_wave #(
		.PHASE_BITS     (PHASE_BITS),
		.SINE_TABLE_BITS(SINE_TABLE_BITS)
	) u_wave (
		.wave_type(wave_type),
		.phase    (phase),
		.sample   (sample)
	);

	assign result_valid = valid_s2;
	assign result       = result_s2;

	a_lock_even: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !result_s2.out_lock_count[0])
		else $error("outgoing lock count is odd");

	a_fire_fills_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> valid_s2)
		else $error("a processed tick left no result");

	a_stall_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && result_stall) |-> tick_stall)
		else $error("input taken while both stages are blocked");

endmodule

// ===== dv/tick_waveform_generator_unit_test.sv =====
`timescale 1ns / 100ps

module tick_waveform_generator_unit_test;
	import twg_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_REPORTS = 10;
	localparam int PH_BITS     = PHASE_BITS_DEF;
	localparam int TBL_BITS    = SINE_TABLE_BITS_DEF;
	localparam int SAMPLE_TOP  = 2**(SAMPLE_BITS-1) - 1;
	localparam int SAMPLE_BOT  = -(2**(SAMPLE_BITS-1));
	localparam logic [7:0] WAVE_SINE = 8'd0;

	logic                      clk          = 1'b0;
	logic                      arst_n       = 1'b0;
	logic                      cfg_write    = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index    = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data     = '0;
	logic                      tick_valid   = 1'b0;
	logic                      tick_stall;
	tick_t                     tick_in      = '0;
	logic                      result_valid;
	logic                      result_stall = 1'b0;
	result_t                   result_out;

	// Generator state as the block should hold it.
	logic [PH_BITS-1:0]         gen_phase      = '0;
	logic [7:0]                 gen_wave_type  = WAVE_SINE;
	logic [7:0]                 gen_held_seq   = '0;
	logic [15:0]                gen_prescale   = '0;
	logic [31:0]                gen_seq_num    = '0;
	logic [15:0]                gen_led_count  = '0;
	logic                       gen_led        = 1'b0;
	logic [31:0]                gen_lock       = '0;
	logic [PHASE_STEP_BITS-1:0] step_setting   = PHASE_STEP_RST;
	logic [PERIOD_BITS-1:0]     seq_period_set = SEQUENCE_PERIOD_RST;
	logic [PERIOD_BITS-1:0]     led_period_set = LED_PERIOD_RST;

	result_t expected_results[$];
	int      mismatch_count = 0;
	int      cycle_count    = 0;
	int      stall_pct      = 0;
	int      hold_left      = 0;

	tick_waveform_generator_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.tick_valid   (tick_valid),
		.tick_stall   (tick_stall),
		.tick         (tick_in),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result_out)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Works out the result of one tick and moves the generator state on.
	function automatic result_t advance_generator(input tick_t t);
		result_t            r;
		int                 v;
		int                 k;
		logic [PH_BITS-1:0] d;
		logic [TBL_BITS-1:0] idx;
		logic [TBL_BITS-2:0] q;
		logic [63:0]        theta;
		logic [63:0]        t2;
		logic [63:0]        term;
		logic [63:0]        acc;
		if (gen_wave_type == WAVE_SQUARE) begin
			v = gen_phase[PH_BITS-1] ? SAMPLE_BOT : SAMPLE_TOP;
		end else if (gen_wave_type == WAVE_TRIANGLE) begin
			d = gen_phase;
			d[PH_BITS-1] = 1'b0;
			v = int'(d >> (PH_BITS - SAMPLE_BITS - 1));
			if (!gen_phase[PH_BITS-1]) begin
				v = v - (SAMPLE_TOP + 1);
			end else begin
				v = (SAMPLE_TOP + 1) - v;
			end
		end else begin
			// Quarter-wave symmetry: fold the index into the first quadrant.
			idx = gen_phase[PH_BITS-1 -: TBL_BITS];
			q = idx[TBL_BITS-3:0];
			if (idx[TBL_BITS-2]) begin
				q = (TBL_BITS-1)'(1 << (TBL_BITS-2)) - q;
			end
			theta = ((64'(q) << (32 - TBL_BITS)) * HALF_PI_Q30) >> 30;
			t2 = (theta * theta) >> 30;
			term = theta;
			acc = theta;
			for (k = 1; k <= 5; k++) begin
				term = ((term * t2) >> 30) / 64'(2 * k * (2 * k + 1));
				if (k % 2 == 1) begin
					acc = acc - term;
				end else begin
					acc = acc + term;
				end
			end
			v = int'((acc + (64'd1 << (30 - SAMPLE_BITS))) >> (31 - SAMPLE_BITS));
			if (idx[TBL_BITS-1]) begin
				v = -v;
			end
		end
		if (v > SAMPLE_TOP) begin
			v = SAMPLE_TOP;
		end else if (v < SAMPLE_BOT) begin
			v = SAMPLE_BOT;
		end
		r.wave_sample  = SAMPLE_BITS'(v);
		r.sequence_out = gen_seq_num;

		gen_phase = gen_phase + PH_BITS'(step_setting);
		if (!t.lock_before[0] && t.lock_before == t.lock_after) begin
			gen_held_seq  = t.mailbox_sequence;
			gen_wave_type = t.mailbox_wave_type;
		end
		gen_lock = gen_lock + 32'd2;
		gen_prescale = gen_prescale + 16'd1;
		if (gen_prescale >= seq_period_set) begin
			gen_prescale = '0;
			gen_seq_num  = gen_seq_num + 32'd1;
		end
		gen_led_count = gen_led_count + 16'd1;
		if (gen_led_count >= led_period_set) begin
			gen_led       = ~gen_led;
			gen_led_count = '0;
		end

		r.out_lock_count    = gen_lock;
		r.received_sequence = gen_held_seq;
		r.led_level         = gen_led;
		return r;
	endfunction

	// Mostly consistent mailbox reads, with busy writers, torn reads and noise mixed in.
	function automatic tick_t random_tick();
		tick_t t;
		int    pick;
		pick = $urandom_range(99);
		t.lock_before = $urandom & 32'hFFFF_FFFE;
		if (pick < 70) begin
			t.lock_after = t.lock_before;
		end else if (pick < 80) begin
			t.lock_before[0] = 1'b1;
			t.lock_after = t.lock_before;
		end else if (pick < 90) begin
			t.lock_after = t.lock_before ^ (32'd1 << $urandom_range(31));
		end else begin
			t.lock_before = $urandom;
			t.lock_after  = $urandom;
		end
		if ($urandom_range(99) < 85) begin
			t.mailbox_wave_type = 8'($urandom_range(2));
		end else begin
			t.mailbox_wave_type = 8'($urandom_range(255));
		end
		t.mailbox_sequence = 8'($urandom_range(255));
		return t;
	endfunction

	task automatic send_tick(input tick_t t);
		tick_in    <= t;
		tick_valid <= 1'b1;
		do @(posedge clk); while (tick_stall);
		expected_results.push_back(advance_generator(t));
	endtask

	task automatic pause_ticks(input int n);
		if (n > 0) begin
			tick_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		tick_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Drains the block, then writes all three registers on back-to-back cycles.
	task automatic load_settings(input logic [PHASE_STEP_BITS-1:0] step,
		input logic [PERIOD_BITS-1:0] seq_period, input logic [PERIOD_BITS-1:0] led_period,
		input int stall_chance);
		wait_idle();
		cfg_write <= 1'b1;
		cfg_index <= CFG_PHASE_STEP;
		cfg_data  <= CFG_DATA_BITS'(step);
		@(posedge clk);
		step_setting = step;
		cfg_index <= CFG_SEQUENCE_PERIOD;
		cfg_data  <= CFG_DATA_BITS'(seq_period);
		@(posedge clk);
		seq_period_set = seq_period;
		cfg_index <= CFG_LED_PERIOD;
		cfg_data  <= CFG_DATA_BITS'(led_period);
		@(posedge clk);
		led_period_set = led_period;
		cfg_write <= 1'b0;
		@(negedge clk);
		stall_pct = stall_chance;
		@(posedge clk);
	endtask

	task automatic send_random(input int n, input int max_gap);
		int burst_left;
		int i;
		burst_left = 0;
		for (i = 0; i < n; i++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				pause_ticks(max_gap == 0 ? 0 : $urandom_range(0, max_gap));
			end
			send_tick(random_tick());
			burst_left--;
		end
	endtask

	function automatic logic [PERIOD_BITS-1:0] random_period();
		int pick;
		pick = $urandom_range(9);
		if (pick < 7) begin
			return PERIOD_BITS'($urandom_range(0, 12));
		end else if (pick < 9) begin
			return PERIOD_BITS'($urandom_range(65535));
		end
		return 16'hFFFF;
	endfunction

	function automatic logic [PHASE_STEP_BITS-1:0] random_step();
		case ($urandom_range(3))
			0: return PHASE_STEP_BITS'($urandom_range(1, 1 << 22));
			1: return PHASE_STEP_BITS'($urandom);
			// Whole table entries, so the sine walks across the index range.
			2: return PHASE_STEP_BITS'($urandom_range(1, 511) << (PH_BITS - TBL_BITS));
			default: return 31'h7FFF_FFFF - PHASE_STEP_BITS'($urandom_range(4095));
		endcase
	endfunction

	// Runs on reset settings: consistent reads of every wave type, busy and torn reads.
	task automatic test_mailbox_reads();
		send_tick('{32'h0000_0000, 32'h0000_0000, WAVE_SQUARE,   8'hFF});
		send_tick('{32'h0000_0000, 32'h0000_0000, WAVE_TRIANGLE, 8'h00});
		send_tick('{32'hFFFF_FFFE, 32'hFFFF_FFFE, WAVE_SINE,     8'hAA});
		send_tick('{32'h0000_0001, 32'h0000_0001, WAVE_SQUARE,   8'h55});
		send_tick('{32'hFFFF_FFFF, 32'hFFFF_FFFF, WAVE_TRIANGLE, 8'h11});
		send_tick('{32'h0000_0002, 32'h0000_0004, WAVE_SQUARE,   8'h22});
		send_tick('{32'h0000_0004, 32'h0000_0002, WAVE_TRIANGLE, 8'h33});
		// Wave type codes outside the defined set fall back to sine.
		send_tick('{32'h8000_0000, 32'h8000_0000, 8'hFF,         8'h80});
		send_tick('{32'h7FFF_FFFE, 32'h7FFF_FFFE, 8'h03,         8'h7F});
		send_tick('{32'h5555_5554, 32'h5555_5554, WAVE_SQUARE,   8'h01});
		send_tick('{32'hAAAA_AAAA, 32'hAAAA_AAAA, WAVE_TRIANGLE, 8'hFE});
		send_tick('{32'h0000_0000, 32'h0000_0000, WAVE_SINE,     8'h00});
	endtask

	// Largest step moves the phase by almost half a turn per tick; zero periods act every tick.
	task automatic test_phase_wrap_and_periods();
		load_settings(31'h7FFF_FFFF, 16'd0, 16'd0, 25);
		send_tick('{32'h10, 32'h10, WAVE_SQUARE,   8'h01});
		send_tick('{32'h10, 32'h10, WAVE_SQUARE,   8'h02});
		send_tick('{32'h10, 32'h10, WAVE_TRIANGLE, 8'h03});
		send_tick('{32'h10, 32'h10, WAVE_TRIANGLE, 8'h04});
		send_tick('{32'h10, 32'h10, WAVE_SINE,     8'h05});
		send_tick('{32'h10, 32'h10, WAVE_SINE,     8'h06});
		send_tick('{32'h10, 32'h10, WAVE_SQUARE,   8'h07});
		load_settings(31'd0, 16'd1, 16'hFFFF, 0);
		send_tick('{32'h20, 32'h20, WAVE_TRIANGLE, 8'h08});
		send_tick('{32'h20, 32'h20, WAVE_SINE,     8'h09});
		send_tick('{32'h20, 32'h20, WAVE_SQUARE,   8'h0A});
		send_tick('{32'h20, 32'h20, WAVE_SINE,     8'h0B});
	endtask

	task automatic test_random_settings();
		int n;
		for (n = 0; n < 8; n++) begin
			load_settings(random_step(), random_period(), random_period(),
				(n % 4 == 0) ? 0 : 20 * $urandom_range(1, 4));
			send_random(150, (n % 3 == 0) ? 0 : 6);
		end
	endtask

	// The receiver holds off long enough for the block to fill and stall its input.
	task automatic test_output_hold();
		load_settings(random_step(), random_period(), random_period(), 0);
		@(negedge clk);
		hold_left = 150;
		@(posedge clk);
		send_random(80, 0);
	endtask

	task automatic test_heavy_backpressure();
		load_settings(random_step(), PERIOD_BITS'($urandom_range(1, 5)),
			PERIOD_BITS'($urandom_range(1, 5)), 80);
		send_random(150, 3);
	endtask

	always @(posedge clk) begin
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else begin
			result_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_valid === 1'b1 && result_stall == 1'b0) begin
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS) begin
					$display("Unexpected result transfer at cycle %0d: %p", cycle_count,
						result_out);
				end
			end else begin
				want = expected_results.pop_front();
				if (want.wave_sample !== result_out.wave_sample ||
					want.sequence_out !== result_out.sequence_out ||
					want.out_lock_count !== result_out.out_lock_count ||
					want.received_sequence !== result_out.received_sequence ||
					want.led_level !== result_out.led_level) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS) begin
						$display("Mismatch at cycle %0d: expected sample %0d seq %0d lock %0d rx %0d led %0d",
							cycle_count, want.wave_sample, want.sequence_out,
							want.out_lock_count, want.received_sequence, want.led_level);
						$display("                      actual sample %0d seq %0d lock %0d rx %0d led %0d",
							result_out.wave_sample, result_out.sequence_out,
							result_out.out_lock_count, result_out.received_sequence,
							result_out.led_level);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_mailbox_reads();
		test_phase_wrap_and_periods();
		test_random_settings();
		test_output_hold();
		test_heavy_backpressure();
		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
